// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the heap queue RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Check that an expression holds at every clock edge outside reset.
`define HMQ_ASSERT_ALWAYS(label, clk, rstn, expr) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (expr)) \
        else $error("heap queue assertion failed");

// Check that a consequent holds in the same cycle as its antecedent.
`define HMQ_ASSERT_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("heap queue assertion failed");

// Check that a consequent holds in the cycle after its antecedent.
`define HMQ_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("heap queue assertion failed");

`else

`define HMQ_ASSERT_ALWAYS(label, clk, rstn, expr)
`define HMQ_ASSERT_IMPLY(label, clk, rstn, ante, cons)
`define HMQ_ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

// ===== rtl/hmq_pkg.sv =====
// Shared constants, types and the key compare function of the heap queue.
package hmq_pkg;

    localparam int CAPACITY      = 64;
    localparam int KEY_WIDTH     = 32;
    localparam int ADDR_W        = $clog2(CAPACITY);
    localparam int CNT_W         = $clog2(CAPACITY + 1);
    localparam int KEY_IN_W      = 32;
    localparam int TOP_KEY_W     = 32;
    localparam int ENTRY_TOTAL_W = 7;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    typedef logic [KEY_WIDTH-1:0] key_t;
    typedef logic [ADDR_W-1:0]    addr_t;
    typedef logic [CNT_W-1:0]     cnt_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef struct packed {
        logic [TOP_KEY_W-1:0]     top_key;
        logic                     top_valid;
        logic [ENTRY_TOTAL_W-1:0] entry_total;
        status_t                  status;
    } hmq_result_t;

    // True when key a is strictly greater than key b in the selected order.
    function automatic logic key_above(key_t a, key_t b, logic signed_keys);
        key_t flip;
        flip = '0;
        flip[KEY_WIDTH-1] = signed_keys;
        return (a ^ flip) > (b ^ flip);
    endfunction

endpackage

// ===== rtl/hmq_ram.sv =====
// Heap key store: one write port, two read ports, registered read data.
module hmq_ram #(
    parameter int DEPTH  = 64,
    parameter int WIDTH  = 32,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_a_addr,
    output logic [WIDTH-1:0]  rd_a_data,
    input  logic [ADDR_W-1:0] rd_b_addr,
    output logic [WIDTH-1:0]  rd_b_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk) begin
        rd_a_data <= mem[rd_a_addr];
        rd_b_data <= mem[rd_b_addr];
    end

endmodule

// ===== rtl/hmq_ctrl.sv =====
// Sift sequencer: walks the heap one level per read, compare and write back.
`include "assert_macros.svh"

module hmq_ctrl import hmq_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        signed_keys,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        in_op,
    input  logic [KEY_IN_W-1:0] in_key,
    output logic        res_valid,
    input  logic        res_ready,
    output hmq_result_t res
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PUSH_CHECK,
        S_PUSH_CMP,
        S_POP_LAST,
        S_POP_CHECK,
        S_POP_CMP,
        S_DONE
    } state_t;

    state_t  state_reg, state_next;
    cnt_t    cnt_reg, cnt_next;
    addr_t   pos_reg, pos_next;
    addr_t   up_reg, up_next;
    key_t    key_reg, key_next;
    key_t    last_reg, last_next;
    key_t    root_reg, root_next;
    status_t status_reg, status_next;

    logic  ram_we;
    addr_t ram_waddr;
    key_t  ram_wdata;
    addr_t rd_a_addr, rd_b_addr;
    key_t  rd_a_data, rd_b_data;

    addr_t             parent_addr;
    logic [ADDR_W+1:0] left_ext;
    logic [ADDR_W+1:0] cnt_ext;
    addr_t             left_addr;
    addr_t             right_addr;
    logic              pick_right;
    addr_t             pick_addr;
    key_t              pick_key;

    hmq_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (KEY_WIDTH)
    ) u_ram (
        .clk       (aclk),
        .wr_en     (ram_we),
        .wr_addr   (ram_waddr),
        .wr_data   (ram_wdata),
        .rd_a_addr (rd_a_addr),
        .rd_a_data (rd_a_data),
        .rd_b_addr (rd_b_addr),
        .rd_b_data (rd_b_data)
    );

    assign parent_addr = (pos_reg - 1'b1) >> 1;
    assign left_ext    = {1'b0, pos_reg, 1'b1};
    assign cnt_ext     = (ADDR_W + 2)'(cnt_reg);
    assign left_addr   = left_ext[ADDR_W-1:0];
    assign right_addr  = left_addr + 1'b1;

    // Take the right child only when it is strictly larger.
    assign pick_right = key_above(rd_b_data, rd_a_data, signed_keys);
    assign pick_addr  = pick_right ? right_addr : left_addr;
    assign pick_key   = pick_right ? rd_b_data : rd_a_data;

    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);

    always_comb begin
        res.top_key     = (cnt_reg != '0) ? TOP_KEY_W'(root_reg) : '0;
        res.top_valid   = (cnt_reg != '0);
        res.entry_total = ENTRY_TOTAL_W'(cnt_reg);
        res.status      = status_reg;
    end

    always_comb begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        pos_next    = pos_reg;
        up_next     = up_reg;
        key_next    = key_reg;
        last_next   = last_reg;
        status_next = status_reg;
        root_next   = root_reg;
        ram_we      = 1'b0;
        ram_waddr   = pos_reg;
        ram_wdata   = key_reg;
        rd_a_addr   = left_addr;
        rd_b_addr   = right_addr;

        case (state_reg)
            S_IDLE: begin
                // Fetch the last entry early in case this is a pop.
                rd_a_addr = addr_t'(cnt_reg - 1'b1);
                if (in_valid) begin
                    key_next    = key_t'(in_key);
                    status_next = ST_DONE;
                    if (in_op == OP_PUSH) begin
                        if (cnt_reg == cnt_t'(CAPACITY)) begin
                            status_next = ST_FULL;
                            state_next  = S_DONE;
                        end else begin
                            pos_next   = addr_t'(cnt_reg);
                            cnt_next   = cnt_reg + 1'b1;
                            state_next = S_PUSH_CHECK;
                        end
                    end else begin
                        if (cnt_reg == '0) begin
                            status_next = ST_EMPTY;
                            state_next  = S_DONE;
                        end else begin
                            cnt_next   = cnt_reg - 1'b1;
                            state_next = S_POP_LAST;
                        end
                    end
                end
            end
            S_PUSH_CHECK: begin
                rd_a_addr = parent_addr;
                if (pos_reg == '0) begin
                    ram_we     = 1'b1;
                    state_next = S_DONE;
                end else begin
                    up_next    = parent_addr;
                    state_next = S_PUSH_CMP;
                end
            end
            S_PUSH_CMP: begin
                ram_we = 1'b1;
                if (key_above(key_reg, rd_a_data, signed_keys)) begin
                    // Move the parent down and climb one level.
                    ram_wdata  = rd_a_data;
                    pos_next   = up_reg;
                    state_next = S_PUSH_CHECK;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_POP_LAST: begin
                last_next  = rd_a_data;
                pos_next   = '0;
                state_next = S_POP_CHECK;
            end
            S_POP_CHECK: begin
                if (left_ext < cnt_ext) begin
                    state_next = S_POP_CMP;
                end else begin
                    ram_we     = 1'b1;
                    ram_wdata  = last_reg;
                    state_next = S_DONE;
                end
            end
            S_POP_CMP: begin
                ram_we = 1'b1;
                if (key_above(pick_key, last_reg, signed_keys)) begin
                    // Move the larger child up and descend one level.
                    ram_wdata  = pick_key;
                    pos_next   = pick_addr;
                    state_next = S_POP_CHECK;
                end else begin
                    ram_wdata  = last_reg;
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        // Mirror the root slot so the maximum is known without a read.
        if (ram_we && ram_waddr == '0) begin
            root_next = ram_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg    <= pos_next;
        up_reg     <= up_next;
        key_reg    <= key_next;
        last_reg   <= last_next;
        root_reg   <= root_next;
        status_reg <= status_next;
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    `HMQ_ASSERT_ALWAYS(a_cnt_bound, aclk, aresetn, cnt_reg <= cnt_t'(CAPACITY))
    `HMQ_ASSERT_IMPLY(a_write_busy, aclk, aresetn, ram_we, state_reg != S_IDLE && state_reg != S_DONE)
    `HMQ_ASSERT_IMPLY(a_pop_right_held, aclk, aresetn, state_reg == S_POP_CHECK && left_ext < cnt_ext, left_ext + 1'b1 <= cnt_ext)
    `HMQ_ASSERT_NEXT(a_push_grows, aclk, aresetn, state_reg == S_IDLE && in_valid && in_op == OP_PUSH && cnt_reg != cnt_t'(CAPACITY), cnt_reg == $past(cnt_reg) + 1'b1)
    `HMQ_ASSERT_NEXT(a_done_holds, aclk, aresetn, state_reg == S_DONE && !res_ready, state_reg == S_DONE && $stable(cnt_reg))

endmodule

// ===== rtl/binary_max_heap_queue_core.sv =====
// Top level of the binary max-heap priority queue: config, sequencer and result register.
//
// Binary max-heap priority queue of up to 64 keys held in one block RAM.
// Each transfer on the s_ channel is a push (s_operation 0, key in s_key_in)
// or a pop of the maximum (s_operation 1); each gives exactly one transfer on
// the m_ channel with the maximum key held afterwards (zero when empty), a
// nonempty flag, the entry count and a status: done, push refused because
// full, or pop refused because empty. Refused operations leave the heap
// untouched. cfg_wr_en/cfg_wr_data set the key order (0 unsigned, 1 two's
// complement); write it only while the queue is idle, and note that entries
// already held are not reordered. Items are handled one at a time. Timing is
// set by the walk through the tree, one level per RAM read, compare and write
// back. The next item is taken in the cycle after the result is handed to the
// m_ register.
// A finished result waits in the m_ register while the next item is taken.
// The RAM needs no clearing pass: a slot's contents are used only after it was written.
module binary_max_heap_queue_core import hmq_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_wr_en,
    input  logic                     cfg_wr_data,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic                     s_operation,
    input  logic [KEY_IN_W-1:0]      s_key_in,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [TOP_KEY_W-1:0]     m_top_key,
    output logic                     m_top_valid,
    output logic [ENTRY_TOTAL_W-1:0] m_entry_total,
    output logic [1:0]               m_status
);

    logic        signed_keys_reg;
    logic        m_valid_reg;
    hmq_result_t m_res_reg;

    logic        res_valid;
    logic        res_ready;
    hmq_result_t res;

    // Accept a new result whenever the output slot is empty or draining.
    assign res_ready = !m_valid_reg || m_ready;

    hmq_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .signed_keys (signed_keys_reg),
        .in_valid    (s_valid),
        .in_ready    (s_ready),
        .in_op       (s_operation),
        .in_key      (s_key_in),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res)
    );

    // Hold the key order; a write takes effect on the next operation.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            signed_keys_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            signed_keys_reg <= cfg_wr_data;
        end
    end

    // Result register: load on handoff from the sequencer, drop on transfer.
    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            m_res_reg <= res;
        end
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_valid && res_ready) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_top_key     = m_res_reg.top_key;
    assign m_top_valid   = m_res_reg.top_valid;
    assign m_entry_total = m_res_reg.entry_total;
    assign m_status      = m_res_reg.status;

endmodule

// ===== sim/heap_queue_checker.sv =====
// Checker that predicts and compares every result of the heap queue core.
`timescale 1ns / 100ps

module heap_queue_checker import hmq_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_wr_en,
    input  logic                     cfg_wr_data,
    input  logic                     s_valid,
    input  logic                     s_ready,
    input  logic                     s_operation,
    input  logic [KEY_IN_W-1:0]      s_key_in,
    input  logic                     m_valid,
    input  logic                     m_ready,
    input  logic [TOP_KEY_W-1:0]     m_top_key,
    input  logic                     m_top_valid,
    input  logic [ENTRY_TOTAL_W-1:0] m_entry_total,
    input  logic [1:0]               m_status,
    output int                       fail_count,
    output int                       pending
);

    key_t        heap_keys [CAPACITY];
    int          held;
    logic        order_signed;
    hmq_result_t expected_tops [$];
    hmq_result_t want;
    int          mismatches;

    initial begin
        mismatches = 0;
        held       = 0;
    end

    function automatic bit outranks(key_t a, key_t b);
        if (order_signed)
            return $signed(a) > $signed(b);
        return a > b;
    endfunction

    // Climb past every strictly smaller parent.
    function automatic void sift_in(key_t key);
        int slot;
        int parent;
        slot = held;
        while (slot != 0) begin
            parent = (slot - 1) / 2;
            if (!outranks(key, heap_keys[parent]))
                break;
            heap_keys[slot] = heap_keys[parent];
            slot = parent;
        end
        heap_keys[slot] = key;
        held++;
    endfunction

    // Move the last entry down; ties between children go to the left one.
    function automatic void sift_out();
        int   slot;
        int   kid;
        key_t last;
        held--;
        last = heap_keys[held];
        slot = 0;
        while (slot * 2 + 1 < held) begin
            kid = slot * 2 + 1;
            if (outranks(heap_keys[kid + 1], heap_keys[kid]))
                kid++;
            if (!outranks(heap_keys[kid], last))
                break;
            heap_keys[slot] = heap_keys[kid];
            slot = kid;
        end
        heap_keys[slot] = last;
    endfunction

    function automatic hmq_result_t heap_step(logic op, key_t key);
        hmq_result_t r;
        r.status = ST_DONE;
        if (op == OP_PUSH) begin
            if (held == CAPACITY)
                r.status = ST_FULL;
            else
                sift_in(key);
        end else begin
            if (held == 0)
                r.status = ST_EMPTY;
            else
                sift_out();
        end
        r.top_key     = (held != 0) ? heap_keys[0] : '0;
        r.top_valid   = (held != 0);
        r.entry_total = ENTRY_TOTAL_W'(held);
        return r;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            held         = 0;
            order_signed = 1'b0;
            expected_tops.delete();
        end else begin
            if (cfg_wr_en)
                order_signed = cfg_wr_data;
            if (m_valid && m_ready) begin
                if (expected_tops.size() == 0) begin
                    $display("%0t: result transfer with nothing expected (top_key %h)",
                             $time, m_top_key);
                    mismatches++;
                end else begin
                    want = expected_tops.pop_front();
                    if (m_top_key !== want.top_key) begin
                        $display("%0t: top_key expected %h actual %h",
                                 $time, want.top_key, m_top_key);
                        mismatches++;
                    end
                    if (m_top_valid !== want.top_valid) begin
                        $display("%0t: top_valid expected %b actual %b",
                                 $time, want.top_valid, m_top_valid);
                        mismatches++;
                    end
                    if (m_entry_total !== want.entry_total) begin
                        $display("%0t: entry_total expected %0d actual %0d",
                                 $time, want.entry_total, m_entry_total);
                        mismatches++;
                    end
                    if (m_status !== want.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, m_status);
                        mismatches++;
                    end
                end
            end
            if (s_valid && s_ready)
                expected_tops.push_back(heap_step(s_operation, s_key_in[KEY_WIDTH-1:0]));
        end
        fail_count <= mismatches;
        pending    <= expected_tops.size();
    end

endmodule

// ===== sim/binary_max_heap_queue_core_tb.sv =====
// Testbench top: stimulus, receiver back-pressure, watchdog and verdict for the heap queue.
`timescale 1ns / 100ps

module binary_max_heap_queue_core_tb;
    import hmq_pkg::*;

    localparam int RANDOM_ITEMS   = 700;
    localparam int HOLD_CYCLES    = 300;   // receiver hold-off, long enough to stall the input
    localparam int WATCHDOG_LIMIT = 2000;  // cycles without any transfer
    localparam int SETTLE_CYCLES  = 40;    // above the worst pop latency

    logic                     aclk          = 1'b0;
    logic                     aresetn       = 1'b0;
    logic                     cfg_wr_en     = 1'b0;
    logic                     cfg_wr_data   = 1'b0;
    logic                     s_valid       = 1'b0;
    logic                     s_ready;
    logic                     s_operation   = OP_PUSH;
    logic [KEY_IN_W-1:0]      s_key_in      = '0;
    logic                     m_valid;
    logic                     m_ready       = 1'b0;
    logic [TOP_KEY_W-1:0]     m_top_key;
    logic                     m_top_valid;
    logic [ENTRY_TOTAL_W-1:0] m_entry_total;
    logic [1:0]               m_status;

    int fail_count;
    int pending;
    int sent      = 0;
    int quiet_run = 0;
    int seg;
    bit steady    = 1'b0;   // both sides run without idling
    bit hold_req  = 1'b0;   // ask the receiver for a long hold-off

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    binary_max_heap_queue_core u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_operation   (s_operation),
        .s_key_in      (s_key_in),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_top_key     (m_top_key),
        .m_top_valid   (m_top_valid),
        .m_entry_total (m_entry_total),
        .m_status      (m_status)
    );

    heap_queue_checker u_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_operation   (s_operation),
        .s_key_in      (s_key_in),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_top_key     (m_top_key),
        .m_top_valid   (m_top_valid),
        .m_entry_total (m_entry_total),
        .m_status      (m_status),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    // Watchdog: end the run if no transfer happens on either channel for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            quiet_run <= 0;
        else
            quiet_run <= quiet_run + 1;
        if (quiet_run >= WATCHDOG_LIMIT) begin
            $display("binary_max_heap_queue_core_tb failed");
            $finish;
        end
    end

    // Receiver: random back-pressure, a hold-off on request, none during steady stretches.
    initial begin
        wait (aresetn === 1'b1);
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                // Hold off while the sender keeps offering, so the core fills and stalls.
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
            end
            m_ready <= steady || ($urandom_range(0, 99) >= 36);
        end
    end

    // Bias keys toward extremes and narrow ranges so equal keys and sign edges show up often.
    function automatic logic [KEY_IN_W-1:0] pick_key();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return 32'h8000_0000;
            3:       return 32'h7FFF_FFFF;
            4, 5:    return KEY_IN_W'($urandom_range(0, 7));
            6:       return 32'hFFFF_FFF8 | KEY_IN_W'($urandom_range(0, 7));
            default: return $urandom;
        endcase
    endfunction

    // Offer one item and wait for its transfer. Valid stays high on return, so the
    // caller must either offer the next item or drop valid in this same step.
    task automatic send(input logic op, input logic [KEY_IN_W-1:0] key);
        while (!steady && $urandom_range(0, 99) < 36) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_operation <= op;
        s_key_in    <= key;
        do @(posedge aclk); while (s_ready !== 1'b1);
        sent++;
    endtask

    // Drop valid and wait until every outstanding result has been transferred.
    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
    endtask

    // Change the key order only while the core is idle.
    task automatic write_order(input logic signed_order);
        drain();
        repeat (4) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= signed_order;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Overfill to hit refused pushes, then drain past empty to hit refused pops.
    task automatic fill_and_drain();
        repeat (CAPACITY + 3) send(OP_PUSH, pick_key());
        repeat (CAPACITY + 3) send(OP_POP, $urandom);
    endtask

    task automatic mixed_run(input int count);
        repeat (count) begin
            if ($urandom_range(0, 99) < 55)
                send(OP_PUSH, pick_key());
            else
                send(OP_POP, $urandom);
        end
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Unsigned order: pop on empty, extremes, equal keys, drain to empty and past it.
        send(OP_POP,  32'h1234_5678);
        send(OP_PUSH, 32'h0000_0000);
        send(OP_PUSH, 32'hFFFF_FFFF);
        send(OP_PUSH, 32'h8000_0000);
        send(OP_PUSH, 32'h7FFF_FFFF);
        send(OP_PUSH, 32'h7FFF_FFFF);
        send(OP_PUSH, 32'h0000_0001);
        repeat (7) send(OP_POP, $urandom);

        // Signed order: the sign bit now ranks lowest.
        write_order(1'b1);
        send(OP_PUSH, 32'h7FFF_FFFF);
        send(OP_PUSH, 32'h8000_0000);
        send(OP_PUSH, 32'hFFFF_FFFF);
        send(OP_PUSH, 32'h0000_0000);
        send(OP_PUSH, 32'hFFFF_FFFF);
        send(OP_POP,  $urandom);

        // Flip back to unsigned with entries still held; they keep their old order.
        write_order(1'b0);
        send(OP_PUSH, 32'h0000_0005);
        send(OP_POP,  $urandom);
        send(OP_POP,  $urandom);

        // Random segments: bursts that reach full and empty, mixed runs, order changes.
        seg = 0;
        while (sent < RANDOM_ITEMS) begin
            steady = (seg == 2);
            if (seg == 3)
                hold_req = 1'b1;
            if (seg == 1 || $urandom_range(0, 9) < 2)
                fill_and_drain();
            else
                mixed_run($urandom_range(20, 40));
            if (seg == 5)
                drain();
            else if ($urandom_range(0, 3) == 0)
                write_order($urandom_range(0, 1));
            seg++;
        end
        steady = 1'b0;

        // Wait out every expected result, then give the core time to show stray output.
        drain();
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (fail_count == 0)
            $display("binary_max_heap_queue_core_tb passed");
        else
            $display("binary_max_heap_queue_core_tb failed");
        $finish;
    end

endmodule
